// ===== hw/rtl/bvma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bvma_pkg;

  localparam int unsigned AdcSampleW = 12;
  localparam int unsigned InTdataW   = 16;
  localparam int unsigned MvW        = 16;
  localparam int unsigned IntervalW  = 16;
  localparam int unsigned GainW      = 32;
  localparam int unsigned ThreshW    = 16;
  localparam int unsigned CfgAddrW   = 2;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned OutTdataW  = 32;
  localparam int unsigned OutTuserW  = 2;
  localparam int unsigned ProdW      = AdcSampleW + GainW;
  localparam int unsigned MvShift    = 16;

  localparam logic [CfgAddrW-1:0] RegInterval  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegGain      = 2'd1;
  localparam logic [CfgAddrW-1:0] RegThreshold = 2'd2;

  localparam logic [IntervalW-1:0] IntervalRst  = 16'd100;
  localparam logic [GainW-1:0]     GainRst      = 32'd105600;
  localparam logic [ThreshW-1:0]   ThresholdRst = 16'd3300;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_LOAD
  } state_e;

  // handshake between the sequencer and a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bvma_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bvma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bvma_mult.sv =====
`timescale 1ns / 1ps
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle
module bvma_mult #(
  parameter int unsigned A_W = 12,
  parameter int unsigned B_W = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [A_W-1:0]       a_i,
  input  wire logic [B_W-1:0]       b_i,
  output bvma_pkg::unit_status_t    status_o,
  output logic      [A_W+B_W-1:0]   prod_o
);

  import bvma_pkg::*;

  localparam int unsigned CntW = $clog2(B_W + 1);

  logic [A_W-1:0]     a_q;
  logic [B_W-1:0]     b_q, b_d;
  logic [A_W+B_W-1:0] acc_q, acc_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [A_W:0]       part;

  assign part = {1'b0, acc_q[A_W+B_W-1:B_W]} + (b_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = CntW'(B_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      b_d   = b_q >> 1;
      acc_d = {part, acc_q[B_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign prod_o        = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bvma_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module bvma_div #(
  parameter int unsigned N_W = 21,
  parameter int unsigned D_W = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [N_W-1:0]     num_i,
  input  wire logic [D_W-1:0]     den_i,
  output bvma_pkg::unit_status_t  status_o,
  output logic      [N_W-1:0]     quo_o
);

  import bvma_pkg::*;

  localparam int unsigned CntW = $clog2(N_W + 1);

  logic [N_W-1:0]  quo_q, quo_d;
  logic [D_W-1:0]  rem_q, rem_d;
  logic [D_W-1:0]  den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [D_W:0]    trial;
  logic [D_W:0]    diff;
  logic            fits;

  assign trial = {rem_q, quo_q[N_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(N_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[N_W-2:0], fits};
      rem_d = fits ? diff[D_W-1:0] : trial[D_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
    end
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quo_o         = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/battery_voltage_moving_average.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Battery voltage moving average. Each input transfer is one millisecond tick
// carrying a converter reading. Every sample_interval_ms ticks the reading is
// scaled to millivolts (unsigned Q16.16 gain, truncated, saturated at 65535),
// pushed into a ring of FILTER_DEPTH samples, and one output transfer carries
// the raw value, the truncated mean of the stored samples, a valid flag once
// the ring is full and a low flag when the mean is below low_threshold_mv.
// A tick that takes no sample is accepted while idle and gives no output.
// A sampled tick keeps the block busy, with s_axis_tready low, while the
// bit-serial multiplier walks the 32 gain bits, then while the restoring
// divider produces one quotient bit per cycle over the running sum of
// SUM_W = 16 + clog2(FILTER_DEPTH + 1) bits. A finished result waits in the
// output register while new ticks are taken. No clearing pass after reset.
module battery_voltage_moving_average #(
  parameter int unsigned FILTER_DEPTH = 16,
  parameter int unsigned ADC_BITS     = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bvma_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  wire logic [bvma_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [bvma_pkg::InTdataW-1:0]      s_axis_tdata,  // [11:0] adc_sample
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [bvma_pkg::OutTdataW-1:0]     m_axis_tdata,  // [15:0] raw_mv, [31:16] average_mv
  output logic      [bvma_pkg::OutTuserW-1:0]     m_axis_tuser   // [0] is_valid, [1] is_low
);

  import bvma_pkg::*;

  localparam int unsigned PosW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FILTER_DEPTH + 1);
  localparam int unsigned SumW = MvW + CntW;
  localparam logic [AdcSampleW-1:0] AdcMask =
    AdcSampleW'((33'd1 << ADC_BITS) - 33'd1);
  localparam logic [PosW-1:0] PosLast = PosW'(FILTER_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FILTER_DEPTH);

  state_e state_q, state_d;

  logic [IntervalW-1:0] interval_q;
  logic [GainW-1:0]     gain_q;
  logic [ThreshW-1:0]   thresh_q;
  logic [IntervalW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [CntW-1:0]      fill_q, fill_d;
  logic [SumW-1:0]      sum_q, sum_d;
  logic [MvW-1:0]       mv_q, mv_next;
  logic                 out_valid_q, out_valid_d;
  logic [MvW-1:0]       out_raw_q, out_avg_q;
  logic                 out_full_q, out_low_q;

  logic                 in_xfer, take_sample, full;
  logic                 ram_re, ram_we, mul_start, div_start, out_load;
  logic [MvW-1:0]       ram_rdata;
  logic [ProdW-1:0]     prod;
  logic [SumW-1:0]      quo;
  unit_status_t         mul_st, div_st;
  logic [AdcSampleW-1:0] adc;

  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign take_sample = !(elapsed_inc < interval_q);
  assign adc         = s_axis_tdata[AdcSampleW-1:0] & AdcMask;
  assign full        = (fill_q == CntFull);
  assign mv_next     = (|prod[ProdW-1:MvShift+MvW]) ? '1 : prod[MvShift+MvW-1:MvShift];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer && take_sample) state_d = ST_MUL;
      ST_MUL:  if (mul_st.done) state_d = ST_SUM;
      ST_SUM:  state_d = ST_DIV;
      ST_DIV:  if (div_st.done) state_d = ST_LOAD;
      ST_LOAD: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    mul_start     = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = s_axis_tvalid && take_sample;
        mul_start     = s_axis_tvalid && take_sample;
      end
      ST_MUL: ;
      ST_SUM: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV: ;
      ST_LOAD: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_comb begin
    elapsed_d = elapsed_q;
    if (in_xfer) begin
      elapsed_d = take_sample ? '0 : elapsed_inc;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (ram_we) begin
      pos_d  = (pos_q == PosLast) ? '0 : pos_q + 1'b1;
      fill_d = full ? fill_q : fill_q + 1'b1;
      sum_d  = sum_q - (full ? {{CntW{1'b0}}, ram_rdata} : '0) + {{CntW{1'b0}}, mv_next};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      interval_q  <= IntervalRst;
      gain_q      <= GainRst;
      thresh_q    <= ThresholdRst;
      elapsed_q   <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegInterval:  interval_q <= cfg_wdata_i[IntervalW-1:0];
          RegGain:      gain_q     <= cfg_wdata_i[GainW-1:0];
          RegThreshold: thresh_q   <= cfg_wdata_i[ThreshW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      mv_q <= mv_next;
    end
    if (out_load) begin
      out_raw_q  <= mv_q;
      out_avg_q  <= quo[MvW-1:0];
      out_full_q <= full;
      out_low_q  <= quo[MvW-1:0] < thresh_q;
    end
  end

  bvma_ram #(
    .WIDTH (MvW),
    .DEPTH (FILTER_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (mv_next),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  bvma_mult #(
    .A_W (AdcSampleW),
    .B_W (GainW)
  ) u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (adc),
    .b_i      (gain_q),
    .status_o (mul_st),
    .prod_o   (prod)
  );

  bvma_div #(
    .N_W (SumW),
    .D_W (CntW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (sum_d),
    .den_i    (fill_d),
    .status_o (div_st),
    .quo_o    (quo)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_avg_q, out_raw_q};
  assign m_axis_tuser  = {out_low_q, out_full_q};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntFull)
    else $error("fill count beyond ring depth");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_st.done |-> state_q == ST_MUL)
    else $error("multiplier finished outside its phase");

  a_avg_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> quo <= {{CntW{1'b0}}, {MvW{1'b1}}})
    else $error("average exceeds 16 bits");

  a_valid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> full)
    else $error("valid flag with ring not full");

  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mul_st.busy && !div_st.busy)
    else $error("arithmetic unit busy while idle");

endmodule

`default_nettype wire

// ===== verif/battery_voltage_moving_average_tb.sv =====
`timescale 1ns / 1ps

module battery_voltage_moving_average_tb;
  import bvma_pkg::*;

  localparam int unsigned RingDepth    = 16;
  localparam int unsigned AdcBits      = 12;
  localparam logic [CfgAddrW-1:0] RegUnused = 2'd3;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned HoldCycles   = 1000;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned RandPhases   = 14;
  localparam int unsigned PhaseTicks   = 70;

  typedef struct packed {
    logic [MvW-1:0] raw_mv;
    logic [MvW-1:0] average_mv;
    logic           is_valid;
    logic           is_low;
  } reading_t;

  class average_tracker;
    logic [IntervalW-1:0]         interval;
    logic [GainW-1:0]             gain;
    logic [ThreshW-1:0]           thresh;
    logic [15:0]                  elapsed;
    logic [MvW-1:0]               ring [RingDepth];
    logic [$clog2(RingDepth)-1:0] wpos;
    logic [4:0]                   fill;
    logic [19:0]                  sum;
    reading_t                     pending_readings [$];
    int unsigned                  errors;

    function new();
      interval = IntervalRst;
      gain     = GainRst;
      thresh   = ThresholdRst;
      elapsed  = '0;
      wpos     = '0;
      fill     = '0;
      sum      = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
      case (addr)
        RegInterval:  interval = data[IntervalW-1:0];
        RegGain:      gain = data[GainW-1:0];
        RegThreshold: thresh = data[ThreshW-1:0];
        default: ;
      endcase
    endfunction

    // one accepted tick
    function void take_tick(logic [AdcBits-1:0] adc);
      logic [AdcBits+GainW-1:0] prod;
      logic [19:0]              quot;
      reading_t                 r;
      if (elapsed != 16'hFFFF) elapsed = elapsed + 1'b1;
      if (elapsed < interval) return;
      elapsed = '0;
      prod = adc * gain;
      if (prod[AdcBits+GainW-1:32] != '0) r.raw_mv = 16'hFFFF;
      else r.raw_mv = prod[31:16];
      if (fill == RingDepth) sum = sum - ring[wpos];
      ring[wpos] = r.raw_mv;
      sum = sum + r.raw_mv;
      wpos = wpos + 1'b1;
      if (fill < RingDepth) fill = fill + 1'b1;
      quot = sum / fill;
      r.average_mv = quot[MvW-1:0];
      r.is_valid = (fill == RingDepth);
      r.is_low = (r.average_mv < thresh);
      pending_readings.push_back(r);
    endfunction

    function void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void match_result(logic [OutTdataW-1:0] tdata, logic [OutTuserW-1:0] tuser);
      reading_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, actual tdata=%h tuser=%b",
                 $time, tdata, tuser);
        return;
      end
      want = pending_readings.pop_front();
      check_field("raw_mv", want.raw_mv, tdata[15:0]);
      check_field("average_mv", want.average_mv, tdata[31:16]);
      check_field("is_valid", want.is_valid, tuser[0]);
      check_field("is_low", want.is_low, tuser[1]);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i    = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;  // [11:0] adc_sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // [15:0] raw_mv, [31:16] average_mv
  logic [OutTuserW-1:0] m_axis_tuser;        // [0] is_valid, [1] is_low

  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  average_tracker book = new();

  battery_voltage_moving_average #(
    .FILTER_DEPTH(RingDepth),
    .ADC_BITS    (AdcBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_tick(input logic [AdcBits-1:0] adc);
    if (!no_idle && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 70) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTdataW-AdcBits){1'b0}}, adc};
    do @(posedge clk_i); while (!s_axis_tready);
    book.take_tick(adc);
  endtask

  function automatic logic [AdcBits-1:0] random_adc();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    return AdcBits'($urandom_range(0, 4095));
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_tick(random_adc());
  endtask

  // wait for all readings, then let any tick still in flight finish
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (book.pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    book.write_reg(addr, data);
  endtask

  task automatic configure(input logic [IntervalW-1:0] interval, input logic [GainW-1:0] gain,
                           input logic [ThreshW-1:0] thresh);
    quiesce();
    write_reg(RegInterval, interval);
    write_reg(RegGain, gain);
    write_reg(RegThreshold, thresh);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) book.match_result(m_axis_tdata, m_axis_tuser);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= rst_ni && (no_idle || $urandom_range(0, 99) >= 33);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
      if (quiet >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("battery_voltage_moving_average test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [AdcBits-1:0]   corner_adc [18];
    logic [IntervalW-1:0] interval;
    logic [GainW-1:0]     gain;
    logic [ThreshW-1:0]   thresh;
    corner_adc = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'hFFE, 12'h800, 12'h7FF,
                   12'hFFF, 12'hFFF, 12'h000, 12'h123, 12'hFED, 12'h400, 12'hC00, 12'h0F0,
                   12'hF0F, 12'h3C3};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset values
    send_random(210);

    // every tick sampled, ring fills and wraps
    configure(16'd1, GainRst, ThresholdRst);
    foreach (corner_adc[i]) send_tick(corner_adc[i]);
    // saturating scale, threshold at top
    configure(16'd1, 32'hFFFF_FFFF, 16'hFFFF);
    send_tick(12'h000);
    send_tick(12'h001);
    send_tick(12'hFFF);
    // interval of zero, zero gain, zero threshold
    configure(16'd0, 32'd0, 16'd0);
    send_tick(12'hFFF);
    send_tick(12'h007);
    // write to an unused index is dropped
    quiesce();
    write_reg(RegUnused, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;
    send_tick(12'h5A5);
    send_tick(12'hA5A);

    for (int p = 0; p < RandPhases; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: interval = 16'd1;
        6:                interval = 16'd2;
        7:                interval = IntervalW'($urandom_range(2, 6));
        8:                interval = 16'd0;
        default:          interval = IntervalW'($urandom_range(3, 20));
      endcase
      case ($urandom_range(0, 5))
        0:       gain = GainRst;
        1:       gain = $urandom();
        2:       gain = $urandom_range(0, 1 << 20);
        3:       gain = 32'hFFFF_FFFF;
        4:       gain = $urandom_range(1 << 18, 1 << 20);
        default: gain = $urandom_range(0, 1000);
      endcase
      case ($urandom_range(0, 3))
        0:       thresh = ThreshW'($urandom_range(0, 65535));
        1:       thresh = 16'd0;
        2:       thresh = 16'hFFFF;
        default: thresh = ThreshW'($urandom_range(0, 20000));
      endcase
      configure(interval, gain, thresh);
      send_random(PhaseTicks);
    end

    // stall the output long enough to back up the input
    configure(16'd1, $urandom_range(0, 1 << 20), ThreshW'($urandom_range(0, 65535)));
    hold_req = 1'b1;
    send_random(40);

    configure(IntervalRst, GainRst, ThreshW'($urandom_range(0, 65535)));
    send_random(150);

    // longest interval, count carries into the next setting
    configure(16'hFFFF, $urandom(), ThreshW'($urandom_range(0, 65535)));
    send_random(40);

    // no idling on either side
    no_idle = 1'b1;
    configure(16'd1, GainRst, ThresholdRst);
    send_random(60);
    no_idle = 1'b0;

    quiesce();
    if (book.errors == 0 && book.pending_readings.size() == 0) begin
      $display("battery_voltage_moving_average test passed");
    end else begin
      if (book.pending_readings.size() != 0)
        $display("%0t: %0d readings never arrived", $time, book.pending_readings.size());
      $display("battery_voltage_moving_average test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bvma_pkg.sv
hw/rtl/bvma_ram.sv
hw/rtl/bvma_mult.sv
hw/rtl/bvma_div.sv
hw/rtl/battery_voltage_moving_average.sv
verif/battery_voltage_moving_average_tb.sv
